FILE: hdl/b2d_pkg.sv
package b2d_pkg;

  localparam int VALUE_W    = 32;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int IDX_W      = $clog2(NUM_DIGITS);
  localparam int CNT_W      = $clog2(VALUE_W);
  localparam int CHAR_W     = 6;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  typedef struct packed {
    logic             done;     // one-cycle pulse, bcd holds the final digits
    logic [IDX_W-1:0] msd_idx;  // index of the most significant nonzero digit
  } b2d_status_t;

endpackage

FILE: hdl/b2d_dabble.sv
module b2d_dabble (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [b2d_pkg::VALUE_W-1:0]  value,
  output logic [b2d_pkg::BCD_W-1:0]    bcd,
  output b2d_pkg::b2d_status_t         status
);
  import b2d_pkg::*;

  logic [VALUE_W-1:0] bin;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic               done;
  logic [BCD_W-1:0]   bcd_adj;
  logic [IDX_W-1:0]   msd_idx;

  // add-3 correction on every digit that is 5 or more, ahead of the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  always_comb begin
    msd_idx = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i*4 +: 4] != 4'd0) begin
        msd_idx = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CNT_W'(VALUE_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(VALUE_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin <= value;
      bcd <= '0;
    end else if (busy) begin
      bcd <= {bcd_adj[BCD_W-2:0], bin[VALUE_W-1]};
      bin <= {bin[VALUE_W-2:0], 1'b0};
    end
  end

  assign status.done    = done;
  assign status.msd_idx = msd_idx;

endmodule

FILE: hdl/binary_to_decimal_ascii.sv
// Converts an unsigned 32-bit number to decimal ASCII text.
// Input channel: in_valid / in_ready with value. One beat is one number.
// Output channel: out_valid / out_ready with digit_char and last. One beat
// per decimal digit, most significant first, no leading zeros; last marks
// the least significant digit. Zero gives a single '0' beat.
// The double-dabble unit shifts one bit per cycle. After its done pulse
// the controller loads the index of the leading digit and shows the
// first digit; digits then follow one per cycle while out_ready is high.
// A number gives 1 to 10 digit beats; the next one is accepted only
// after its last beat; in_ready is high only while no number is in flight.
// A stall on the output holds the current digit steady until taken; the
// converter simply waits.
// Reset (rst, synchronous, active high) drops any number in flight and
// returns the block to ready.
module binary_to_decimal_ascii (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [b2d_pkg::VALUE_W-1:0]  value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [b2d_pkg::CHAR_W-1:0]   digit_char,
  output logic                         last
);
  import b2d_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state;
  logic [IDX_W-1:0] idx;
  logic [BCD_W-1:0] bcd;
  b2d_status_t      status;
  logic             start;
  logic [3:0]       digit;

  assign in_ready = (state == ST_IDLE);
  assign start    = in_valid && in_ready;

  b2d_dabble u_dabble (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .value  (value),
    .bcd    (bcd),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (status.done) begin
            idx   <= status.msd_idx;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_ready) begin
            if (idx == '0) begin
              state <= ST_IDLE;
            end else begin
              idx <= idx - 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign digit      = bcd[idx*4 +: 4];
  assign out_valid  = (state == ST_EMIT);
  assign digit_char = ASCII_ZERO + {{(CHAR_W-4){1'b0}}, digit};
  assign last       = (idx == '0);

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import b2d_pkg::*;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              fin;
  } digit_beat_t;

  typedef struct {
    logic [VALUE_W-1:0] num;
    string              text;   // empty: digits come from the predictor
  } directed_row_t;

  localparam int STALL_LIMIT      = 3000;
  localparam int SETTLE_CYCLES    = 60;
  localparam int RANDOM_PER_PHASE = 70;
  localparam int NUM_DIRECTED     = 20;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic [VALUE_W-1:0]  value     = '0;
  logic                out_ready = 1'b0;
  logic                in_ready;
  logic                out_valid;
  logic [CHAR_W-1:0]   digit_char;
  logic                last;

  digit_beat_t   pending_digits [$];
  digit_beat_t   head_digit;
  directed_row_t directed_rows [NUM_DIRECTED];

  int src_idle_pct   = 26;
  int dst_idle_pct   = 50;
  int mismatches     = 0;
  int digits_checked = 0;
  int numbers_sent   = 0;
  int longest_number = 0;
  int stall_cycles   = 0;

  always #6 clk = ~clk;

  binary_to_decimal_ascii dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digit_char (digit_char),
    .last       (last)
  );

  // Decimal digits of num, most significant first, into the pending queue.
  function automatic void queue_decimal(input logic [VALUE_W-1:0] num);
    logic [3:0]         rev [NUM_DIGITS];
    logic [VALUE_W-1:0] rest;
    int                 n;
    rest = num;
    n = 0;
    do begin
      rev[n] = 4'(rest % 10);
      rest = rest / 10;
      n++;
    end while (rest != 0);
    for (int k = 0; k < n; k++) begin
      pending_digits.push_back('{ch: ASCII_ZERO + CHAR_W'(rev[n-1-k]), fin: (k == n - 1)});
    end
    if (n > longest_number) longest_number = n;
  endfunction

  function automatic void queue_text(input string text);
    for (int i = 0; i < text.len(); i++) begin
      pending_digits.push_back('{ch: CHAR_W'(text[i]), fin: (i == text.len() - 1)});
    end
    if (text.len() > longest_number) longest_number = text.len();
  endfunction

  function automatic longint pow10(input int k);
    longint p;
    p = 1;
    repeat (k) p = p * 10;
    return p;
  endfunction

  // Mix of full-range words, values around powers of ten, and values with
  // a uniformly chosen digit count so short numbers are not starved.
  function automatic logic [VALUE_W-1:0] random_number();
    longint lo;
    longint hi;
    int     pick;
    int     n;
    pick = $urandom_range(99);
    if (pick < 20) return $urandom();
    if (pick < 40) return VALUE_W'(pow10($urandom_range(9, 1)) + $urandom_range(2) - 1);
    n = $urandom_range(10, 1);
    lo = (n == 1) ? 0 : pow10(n - 1);
    hi = pow10(n) - 1;
    if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
    return VALUE_W'(lo + $urandom_range(32'(hi - lo)));
  endfunction

  // Called right after a rising edge; returns at the edge the beat is taken.
  task automatic send_number(input logic [VALUE_W-1:0] num, input string text);
    int gap;
    gap = 0;
    while (gap < 24 && $urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= num;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (text.len() == 0) queue_decimal(num);
    else queue_text(text);
    numbers_sent++;
  endtask

  task automatic drain_digits();
    in_valid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= dst_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      digits_checked++;
      if (pending_digits.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: digit 0x%02h last=%0b with no number pending", $realtime,
                   digit_char, last);
        mismatches++;
      end else begin
        head_digit = pending_digits.pop_front();
        if (digit_char !== head_digit.ch || last !== head_digit.fin) begin
          if (mismatches < 10)
            $display("%0t: digit_char exp 0x%02h got 0x%02h, last exp %0b got %0b",
                     $realtime, head_digit.ch, digit_char, head_digit.fin, last);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: cycles with no beat on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d digits outstanding", STALL_LIMIT,
               pending_digits.size());
      $display("testbench: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    directed_rows = '{
      '{32'd0,          "0"},
      '{32'd1,          "1"},
      '{32'd9,          "9"},
      '{32'd10,         "10"},
      '{32'd11,         ""},
      '{32'd19,         ""},
      '{32'd99,         "99"},
      '{32'd100,        "100"},
      '{32'd1000,       "1000"},
      '{32'd65535,      ""},
      '{32'd999999999,  "999999999"},
      '{32'd1000000000, "1000000000"},
      '{32'd1234567890, "1234567890"},
      '{32'h7FFF_FFFF,  ""},
      '{32'h8000_0000,  ""},
      '{32'hAAAA_AAAA,  ""},
      '{32'h5555_5555,  ""},
      '{32'hFFFF_FFFE,  "4294967294"},
      '{32'hFFFF_FFFF,  "4294967295"},
      '{32'd0,          "0"}
    };
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) send_number(directed_rows[i].num, directed_rows[i].text);
    repeat (RANDOM_PER_PHASE) send_number(random_number(), "");
    drain_digits();

    src_idle_pct = 50;
    dst_idle_pct = 26;
    repeat (RANDOM_PER_PHASE) send_number(random_number(), "");
    drain_digits();

    src_idle_pct = 0;
    dst_idle_pct = 0;
    repeat (RANDOM_PER_PHASE) send_number(random_number(), "");
    drain_digits();

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("converted %0d numbers into %0d digit beats, up to %0d digits each",
             numbers_sent, digits_checked, longest_number);
    $display("three stall profiles on both channels, %0d mismatches", mismatches);
    if (mismatches == 0 && pending_digits.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
